// ----- design/deq_pkg.sv -----
// Shared types, constants and pointer helpers for the double-ended queue.
package deq_pkg;

   // Storage geometry
   localparam int DEPTH  = 16;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;
   localparam int OP_W   = 3;
   localparam int FILL_W = 5;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [WORD_W-1:0] word_type;

   // Operation codes
   typedef enum logic [OP_W-1:0] {
      OP_PUSH_LEFT  = 3'd0,
      OP_PUSH_RIGHT = 3'd1,
      OP_POP_LEFT   = 3'd2,
      OP_POP_RIGHT  = 3'd3,
      OP_SEARCH     = 3'd4
   } op_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP_WAIT,
      ST_SEARCH
   } st_type;

   // Storage port request: one write and one read address per cycle
   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      word_type wr_data;
      addr_type rd_addr;
   } mem_req_type;

   // Sequencer status seen by the top level
   typedef struct packed {
      st_type  state;
      cnt_type count;
   } seq_stat_type;

   // Ring pointer plus offset; offset is below DEPTH, so one subtract wraps it
   function automatic addr_type ptr_add(addr_type a, cnt_type b);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
      if (s >= (CNT_W+1)'(DEPTH)) begin
         s = s - (CNT_W+1)'(DEPTH);
      end
      return addr_type'(s);
   endfunction

   // Ring pointer minus one
   function automatic addr_type ptr_dec(addr_type a);
      addr_type r;
      if (a == '0) begin
         r = addr_type'(DEPTH - 1);
      end else begin
         r = a - addr_type'(1);
      end
      return r;
   endfunction

endpackage

// ----- design/deq_mem.sv -----
// Word storage of the ring buffer: one write port, one registered read port.
module deq_mem import deq_pkg::*; (
   input  logic        clock,
   input  mem_req_type mem_req,
   output word_type    rd_data
);

   word_type store_ff [DEPTH];
   word_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/deq_seq.sv -----
// Sequencer: pointers, fill count, search walk with the shared key comparator.
module deq_seq import deq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [2:0]   req_opcode,
   input  word_type     req_value,
   output mem_req_type  mem_req,
   input  word_type     rd_data,
   output logic         rsp_strobe,
   output word_type     rsp_data_out,
   output logic         rsp_ok,
   output logic         rsp_found,
   output cnt_type      rsp_count,
   output seq_stat_type stat
);

   st_type   state_ff, state_in;
   addr_type head_ff, head_in;
   cnt_type  count_ff, count_in;
   cnt_type  idx_ff, idx_in;
   logic     pend_ff, pend_in;
   logic     found_ff, found_in;
   word_type key_ff, key_in;
   logic     strobe_ff, strobe_in;
   word_type data_ff, data_in;
   logic     ok_ff, ok_in;
   logic     fnd_ff, fnd_in;

   logic full, empty, accept, hit;

   assign full   = (count_ff == cnt_type'(DEPTH));
   assign empty  = (count_ff == '0);
   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   // shared comparator: stored word read last cycle against the key
   assign hit    = pend_ff && (rd_data == key_ff);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
         pend_ff   <= pend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      found_ff <= found_in;
      key_ff   <= key_in;
      data_ff  <= data_in;
      ok_ff    <= ok_in;
      fnd_ff   <= fnd_in;
   end

   // Next state and outputs
   always_comb begin
      state_in        = state_ff;
      head_in         = head_ff;
      count_in        = count_ff;
      idx_in          = idx_ff;
      pend_in         = 1'b0;
      found_in        = found_ff;
      key_in          = key_ff;
      strobe_in       = 1'b0;
      data_in         = '0;
      ok_in           = 1'b0;
      fnd_in          = 1'b0;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = ptr_dec(head_ff);
      mem_req.wr_data = req_value;
      mem_req.rd_addr = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_PUSH_LEFT: begin
                     strobe_in = 1'b1;
                     if (!full) begin
                        mem_req.wr_en = 1'b1;
                        head_in       = ptr_dec(head_ff);
                        count_in      = count_ff + cnt_type'(1);
                        ok_in         = 1'b1;
                     end
                  end
                  OP_PUSH_RIGHT: begin
                     strobe_in = 1'b1;
                     if (!full) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = ptr_add(head_ff, count_ff);
                        count_in        = count_ff + cnt_type'(1);
                        ok_in           = 1'b1;
                     end
                  end
                  OP_POP_LEFT: begin
                     if (empty) begin
                        strobe_in = 1'b1;
                     end else begin
                        mem_req.rd_addr = head_ff;
                        head_in         = ptr_add(head_ff, cnt_type'(1));
                        count_in        = count_ff - cnt_type'(1);
                        state_in        = ST_POP_WAIT;
                     end
                  end
                  OP_POP_RIGHT: begin
                     if (empty) begin
                        strobe_in = 1'b1;
                     end else begin
                        mem_req.rd_addr = ptr_add(head_ff, count_ff - cnt_type'(1));
                        count_in        = count_ff - cnt_type'(1);
                        state_in        = ST_POP_WAIT;
                     end
                  end
                  OP_SEARCH: begin
                     key_in   = req_value;
                     idx_in   = '0;
                     found_in = 1'b0;
                     state_in = ST_SEARCH;
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_POP_WAIT: begin
            strobe_in = 1'b1;
            data_in   = rd_data;
            ok_in     = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_SEARCH: begin
            if (idx_ff != count_ff) begin
               // issue the next read, compare the previous one
               mem_req.rd_addr = ptr_add(head_ff, idx_ff);
               idx_in          = idx_ff + cnt_type'(1);
               pend_in         = 1'b1;
               found_in        = found_ff | hit;
            end else if (pend_ff) begin
               // last compare drains
               found_in = found_ff | hit;
            end else begin
               // walk done: report and, on a hit, prepend a copy if there is room
               strobe_in       = 1'b1;
               fnd_in          = found_ff;
               mem_req.wr_data = key_ff;
               if (found_ff && !full) begin
                  mem_req.wr_en = 1'b1;
                  head_in       = ptr_dec(head_ff);
                  count_in      = count_ff + cnt_type'(1);
                  ok_in         = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_data_out = data_ff;
   assign rsp_ok       = ok_ff;
   assign rsp_found    = fnd_ff;
   assign rsp_count    = count_ff;
   assign stat.state   = state_ff;
   assign stat.count   = count_ff;

endmodule

// ----- design/double_ended_queue_with_search.sv -----
// Top level of the double-ended queue with search.
//
//   Channel   Handshake              Payload
//   request   start / busy           req_opcode, req_value
//   response  rsp_strobe (1 cycle)   rsp_data_out, rsp_ok, rsp_found, rsp_fill
//
// Pushes, failed pops and unknown opcodes: result in the cycle after the transfer,
// next item may follow at once. Successful pops: busy in ST_POP_WAIT, result after it.
// Search: busy for the whole walk; one stored word per cycle goes through the single key
// comparator, then on a hit the copy is written at the left end if there is room.
// Reset empties the queue; stored words are not cleared.
// Results cannot be stalled: each is shown for exactly one cycle.
module double_ended_queue_with_search import deq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [OP_W-1:0]   req_opcode,
   input  logic signed [WORD_W-1:0] req_value,
   output logic              rsp_strobe,
   output logic signed [WORD_W-1:0] rsp_data_out,
   output logic              rsp_ok,
   output logic              rsp_found,
   output logic [FILL_W-1:0] rsp_fill
);

   mem_req_type  mem_req;
   word_type     rd_data;
   word_type     data_out;
   cnt_type      count;
   seq_stat_type stat;

   // Sequencer with pointers and comparator
   deq_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_opcode   (req_opcode),
      .req_value    (word_type'(req_value)),
      .mem_req      (mem_req),
      .rd_data      (rd_data),
      .rsp_strobe   (rsp_strobe),
      .rsp_data_out (data_out),
      .rsp_ok       (rsp_ok),
      .rsp_found    (rsp_found),
      .rsp_count    (count),
      .stat         (stat)
   );

   // Word storage
   deq_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign rsp_data_out = $signed(data_out);
   assign rsp_fill     = FILL_W'(count);

   // Every transfer either reports next cycle or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("transfer neither reported nor in progress");

   // Fill never exceeds the storage depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stat.count <= cnt_type'(DEPTH))
      else $error("fill count above depth");

   // A failed item (rsp_ok low) reports a zero word
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_ok) |-> (rsp_data_out == '0))
      else $error("data reported without a pop");

   // A search hit leaves at least one word stored
   a_found_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_found) |-> (stat.count != '0))
      else $error("key found in an empty store");

endmodule

// ----- test/double_ended_queue_with_search_checker.sv -----
// Checker for the deque: mirrors its contents, predicts each result and compares.
module double_ended_queue_with_search_checker import deq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic [OP_W-1:0]          req_opcode,
   input  logic signed [WORD_W-1:0] req_value,
   input  logic                     rsp_strobe,
   input  logic signed [WORD_W-1:0] rsp_data_out,
   input  logic                     rsp_ok,
   input  logic                     rsp_found,
   input  logic [FILL_W-1:0]        rsp_fill,
   output int                       fail_count,
   output int                       pending,
   output int                       results,
   output int                       full_rejects,
   output int                       empty_pops,
   output int                       search_hits
);

   typedef struct packed {
      word_type            data;
      logic                ok;
      logic                found;
      logic [FILL_W-1:0]   fill;
   } reply_type;

   // Mirror of the ring contents
   word_type  words [DEPTH];
   addr_type  left_idx = '0;
   cnt_type   n_words = '0;

   // Results still owed by the block, oldest first
   reply_type owed_replies [$];

   int n_fail  = 0;
   int n_res   = 0;
   int n_full  = 0;
   int n_empty = 0;
   int n_hit   = 0;

   // Ring position of the word at a given distance from the left end
   function automatic addr_type slot(int offset);
      return addr_type'((int'(left_idx) + offset) % DEPTH);
   endfunction

   function automatic logic insert_left(word_type w);
      if (n_words >= DEPTH) begin
         return 1'b0;
      end
      left_idx = slot(DEPTH - 1);
      words[left_idx] = w;
      n_words++;
      return 1'b1;
   endfunction

   // Applies one operation to the mirror and returns the result it yields
   function automatic reply_type apply_deque_op(logic [OP_W-1:0] op, word_type w);
      reply_type r;
      r = '0;
      case (op)
         OP_PUSH_LEFT: begin
            r.ok = insert_left(w);
         end
         OP_PUSH_RIGHT: begin
            if (n_words < DEPTH) begin
               words[slot(n_words)] = w;
               n_words++;
               r.ok = 1'b1;
            end
         end
         OP_POP_LEFT: begin
            if (n_words != 0) begin
               r.data = words[left_idx];
               left_idx = slot(1);
               n_words--;
               r.ok = 1'b1;
            end
         end
         OP_POP_RIGHT: begin
            if (n_words != 0) begin
               r.data = words[slot(n_words - 1)];
               n_words--;
               r.ok = 1'b1;
            end
         end
         OP_SEARCH: begin
            for (int i = 0; i < n_words; i++) begin
               if (words[slot(i)] == w) begin
                  r.found = 1'b1;
               end
            end
            if (r.found) begin
               r.ok = insert_left(w);
            end
         end
         default: ;
      endcase
      r.fill = FILL_W'(n_words);
      return r;
   endfunction

   function automatic void note_mismatch(string field, int want_v, int got_v);
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, field, want_v, got_v);
      n_fail++;
   endfunction

   always @(posedge clock) begin
      reply_type want;
      reply_type got;
      if (reset) begin
         left_idx = '0;
         n_words  = '0;
         owed_replies.delete();
      end else begin
         // result side: compare against the oldest owed result
         if (rsp_strobe) begin
            got = '{rsp_data_out, rsp_ok, rsp_found, rsp_fill};
            n_res++;
            if (owed_replies.size() == 0) begin
               $display("%0t: unexpected result: data %0d ok %0d found %0d fill %0d",
                        $time, $signed(got.data), got.ok, got.found, got.fill);
               n_fail++;
            end else begin
               want = owed_replies.pop_front();
               if (got.data !== want.data) begin
                  note_mismatch("data_out", want.data, got.data);
               end
               if (got.ok !== want.ok) begin
                  note_mismatch("ok", want.ok, got.ok);
               end
               if (got.found !== want.found) begin
                  note_mismatch("found", want.found, got.found);
               end
               if (got.fill !== want.fill) begin
                  note_mismatch("fill", want.fill, got.fill);
               end
            end
         end
         // request side: predict on each transfer
         if (start && !busy) begin
            want = apply_deque_op(req_opcode, req_value);
            if ((req_opcode == OP_PUSH_LEFT || req_opcode == OP_PUSH_RIGHT ||
                 (req_opcode == OP_SEARCH && want.found)) && !want.ok) begin
               n_full++;
            end
            if ((req_opcode == OP_POP_LEFT || req_opcode == OP_POP_RIGHT) && !want.ok) begin
               n_empty++;
            end
            if (req_opcode == OP_SEARCH && want.found) begin
               n_hit++;
            end
            owed_replies.push_back(want);
         end
      end
      fail_count   <= n_fail;
      pending      <= owed_replies.size();
      results      <= n_res;
      full_rejects <= n_full;
      empty_pops   <= n_empty;
      search_hits  <= n_hit;
   end

endmodule

// ----- test/double_ended_queue_with_search_tb.sv -----
// Testbench top for the deque: clock, reset, stimulus, watchdog and verdict.
module double_ended_queue_with_search_tb;
   import deq_pkg::*;

   localparam int ITEMS      = 1550;
   localparam int IDLE_LIMIT = 500;
   localparam int RECENT_N   = 8;

   // Operation mix of a stretch of random stimulus
   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_SEARCH} mix_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     start      = 1'b0;
   logic [OP_W-1:0]          req_opcode = '0;
   logic signed [WORD_W-1:0] req_value  = '0;
   logic                     busy;
   logic                     rsp_strobe;
   logic signed [WORD_W-1:0] rsp_data_out;
   logic                     rsp_ok;
   logic                     rsp_found;
   logic [FILL_W-1:0]        rsp_fill;

   int fail_count;
   int pending;
   int results;
   int full_rejects;
   int empty_pops;
   int search_hits;

   // Recently pushed words, used as search keys so that searches can hit
   word_type recent_words [RECENT_N];
   int       recent_idx  = 0;
   int       sent        = 0;
   int       idle_cycles = 0;

   always #4 clock = ~clock;

   double_ended_queue_with_search u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_opcode   (req_opcode),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_data_out (rsp_data_out),
      .rsp_ok       (rsp_ok),
      .rsp_found    (rsp_found),
      .rsp_fill     (rsp_fill)
   );

   double_ended_queue_with_search_checker u_chk (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_opcode   (req_opcode),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_data_out (rsp_data_out),
      .rsp_ok       (rsp_ok),
      .rsp_found    (rsp_found),
      .rsp_fill     (rsp_fill),
      .fail_count   (fail_count),
      .pending      (pending),
      .results      (results),
      .full_rejects (full_rejects),
      .empty_pops   (empty_pops),
      .search_hits  (search_hits)
   );

   // Random word, weighted toward extremes and a small pool that repeats
   function automatic word_type pick_word();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return '0;
         3:       return '1;
         4, 5:    return word_type'($urandom_range(0, 15));
         default: return word_type'($urandom());
      endcase
   endfunction

   // One transfer; start stays high on return so the next item may follow at once
   task automatic send_item(logic [OP_W-1:0] op, word_type w);
      start      <= 1'b1;
      req_opcode <= op;
      req_value  <= w;
      if (op <= OP_SEARCH) begin
         sent++;
      end
      if (op == OP_PUSH_LEFT || op == OP_PUSH_RIGHT) begin
         recent_words[recent_idx] = w;
         recent_idx = (recent_idx + 1) % RECENT_N;
      end
      do @(posedge clock); while (busy);
   endtask

   task automatic send_random(mix_type mix);
      int               roll;
      int               push_pct;
      int               pop_pct;
      logic [OP_W-1:0]  op;
      word_type         w;
      case (mix)
         MIX_FILL:  begin push_pct = 70; pop_pct = 15; end
         MIX_DRAIN: begin push_pct = 15; pop_pct = 70; end
         MIX_EVEN:  begin push_pct = 40; pop_pct = 40; end
         default:   begin push_pct = 30; pop_pct = 30; end
      endcase
      w    = pick_word();
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 3) begin
         op = OP_W'($urandom_range(int'(OP_SEARCH) + 1, (1 << OP_W) - 1));
      end else if (roll < push_pct) begin
         op = $urandom_range(0, 1) ? OP_PUSH_RIGHT : OP_PUSH_LEFT;
      end else if (roll < push_pct + pop_pct) begin
         op = $urandom_range(0, 1) ? OP_POP_RIGHT : OP_POP_LEFT;
      end else begin
         op = OP_SEARCH;
         if ($urandom_range(0, 3) != 0) begin
            w = recent_words[$urandom_range(0, RECENT_N - 1)];
         end
      end
      send_item(op, w);
   endtask

   // Stimulus
   initial begin
      int      seg_left;
      int      burst;
      bit      drained;
      mix_type mix;
      seg_left = 0;
      drained  = 1'b0;
      mix      = MIX_EVEN;
      foreach (recent_words[i]) begin
         recent_words[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty queue, unused opcodes, extreme words, search hit and miss
      send_item(OP_POP_LEFT, 32'h7fff_ffff);
      send_item(OP_POP_RIGHT, 32'h8000_0000);
      send_item(OP_SEARCH, '0);
      for (int c = int'(OP_SEARCH) + 1; c < (1 << OP_W); c++) begin
         send_item(OP_W'(c), pick_word());
      end
      send_item(OP_PUSH_LEFT, 32'h8000_0000);
      send_item(OP_PUSH_RIGHT, 32'h7fff_ffff);
      send_item(OP_PUSH_LEFT, '1);
      send_item(OP_PUSH_RIGHT, '0);
      send_item(OP_SEARCH, 32'h7fff_ffff);
      send_item(OP_SEARCH, 32'h1234_5678);
      send_item(OP_SEARCH, 32'h8000_0000);
      send_item(OP_POP_LEFT, '0);
      send_item(OP_POP_RIGHT, '1);
      send_item(OP_POP_RIGHT, '0);
      send_item(OP_POP_LEFT, '0);
      send_item(OP_POP_LEFT, '0);
      send_item(OP_POP_RIGHT, '0);
      send_item(OP_POP_LEFT, '0);
      send_item(OP_POP_RIGHT, '0);

      // random: bursts with gaps, stretches that fill, drain or search
      while (sent < ITEMS) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
         repeat (burst) begin
            if (seg_left == 0) begin
               mix      = mix_type'($urandom_range(0, 3));
               seg_left = $urandom_range(20, 60);
            end
            seg_left--;
            send_random(mix);
         end
         start <= 1'b0;
         if (!drained && sent > ITEMS / 2) begin
            // hold off until the block owes nothing
            do @(posedge clock); while (pending != 0);
            drained = 1'b1;
         end else begin
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end

      // let the last results come out
      do @(posedge clock); while (pending != 0);
      repeat (24) @(posedge clock);
      $display("Ran %0d operations, %0d results checked, %0d search hits.",
               sent, results, search_hits);
      $display("Refused on a full queue: %0d; pops on an empty queue: %0d.",
               full_rejects, empty_pops);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog: ends the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles < IDLE_LIMIT) begin
         idle_cycles <= idle_cycles + 1;
      end else begin
         $display("%0t: timeout, no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

endmodule
